/* rtl/vwsx_pkg.sv */
// Package for the LEB128 word stream decoder with XOR check.
// Holds the byte-format constants, the frame status codes and the decoder info struct.
// No dependencies.
`default_nettype none

package vwsx_pkg;

	localparam int unsigned SHIFT_W = 7;
	localparam logic [7:0] PAYLOAD_MASK = 8'h7F;
	localparam logic [7:0] CONT_FLAG = 8'h80;
	localparam logic [SHIFT_W-1:0] GROUP_STEP = 7'd7;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FEW      = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_TRUNC    = 2'd3
	} status_t;

	typedef struct packed {
		logic    emit;
		logic    frame_end;
		status_t status;
	} vwsx_info_t;

endpackage

`default_nettype wire

/* rtl/vwsx_decode.sv */
// Frame state and per-byte decode: word accumulator, group shift, running check.
// Depends on vwsx_pkg.
`default_nettype none

module vwsx_decode import vwsx_pkg::*; #(
	parameter int unsigned WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           byte_value,
	input  logic                 frame_last,
	output logic [WORD_BITS-1:0] word_value,
	output vwsx_info_t           info
);

	logic [WORD_BITS-1:0] acc_q;
	logic [SHIFT_W-1:0]   shift_q;
	logic [WORD_BITS-1:0] check_q;
	logic                 seen_q;

	logic                 in_range;
	logic                 more;
	logic [WORD_BITS-1:0] group;
	logic [WORD_BITS-1:0] word;

	assign in_range = shift_q < SHIFT_W'(WORD_BITS);
	assign more     = (byte_value & CONT_FLAG) != 8'd0;
	assign group    = WORD_BITS'(byte_value & PAYLOAD_MASK) << shift_q;
	assign word     = in_range ? (acc_q | group) : acc_q;

	always_comb begin
		info.emit      = frame_last || !more;
		info.frame_end = frame_last;
		info.status    = ST_OK;
		word_value     = word;
		if (frame_last) begin
			if (more) begin
				info.status = ST_TRUNC;
				word_value  = '0;
			end else if (!seen_q) begin
				info.status = ST_FEW;
			end else if (check_q != word) begin
				info.status = ST_MISMATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			shift_q <= '0;
			check_q <= '0;
			seen_q  <= 1'b0;
		end else if (step) begin
			if (frame_last) begin
				acc_q   <= '0;
				shift_q <= '0;
				check_q <= '0;
				seen_q  <= 1'b0;
			end else if (!more) begin
				acc_q   <= '0;
				shift_q <= '0;
				check_q <= check_q ^ word;
				seen_q  <= 1'b1;
			end else begin
				acc_q <= word;
				if (in_range) begin
					shift_q <= shift_q + GROUP_STEP;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/varint_word_stream_xor_checker_core.sv */
// Top level of the LEB128 word stream decoder with XOR check: input register,
// decode stage and result register. Depends on vwsx_pkg and vwsx_decode.
//
//   channel  dir  tdata                              tlast         tuser
//   s_*      in   [7:0] byte_value                   frame_last    -
//   m_*      out  [WORD_BITS-1:0] word_value, pad 0  is_frame_end  [1:0] frame_status
//
// One byte per cycle sustained while m_* is not stalled.
// The input register feeds the decode stage, which loads the result register.
// arst_n clears all frame state and both valid flags.
// A stalled m_* holds its result; s_tready drops only when the input register
// is full and cannot advance into a busy result register.
`default_nettype none

module varint_word_stream_xor_checker_core import vwsx_pkg::*; #(
	parameter int unsigned WORD_BITS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // byte_value
	input  logic                                s_tlast,  // frame_last
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((WORD_BITS+7)/8)*8-1:0]      m_tdata,  // word_value, zero pad
	output logic                                m_tlast,  // is_frame_end
	output logic [1:0]                          m_tuser   // frame_status
);

	localparam int unsigned DATA_W = ((WORD_BITS + 7) / 8) * 8;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	logic                 adv_s1;

	logic                 out_valid_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 end_q;
	status_t              status_q;

	logic [WORD_BITS-1:0] dec_word;
	vwsx_info_t           dec_info;

	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	vwsx_decode #(
		.WORD_BITS(WORD_BITS)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.byte_value(byte_s1),
		.frame_last(last_s1),
		.word_value(dec_word),
		.info      (dec_info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && dec_info.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && dec_info.emit) begin
			word_q   <= dec_word;
			end_q    <= dec_info.frame_end;
			status_q <= dec_info.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_W'(word_q);
	assign m_tlast  = end_q;
	assign m_tuser  = status_q;

`ifndef NO_ASSERTIONS
	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == ST_OK)
		else $error("nonzero status on a word that does not end the frame");

	a_trunc_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_TRUNC |-> m_tdata == '0)
		else $error("truncated frame carries a nonzero word");

	a_emit_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && dec_info.emit |=> m_tvalid)
		else $error("decoded request did not reach the result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |-> !out_valid_q || m_tready)
		else $error("decode stage advanced into a stalled result");
`endif

endmodule

`default_nettype wire
